>>> sv/adm_pkg.sv
// Shared constants, codes and types of the ancestor demand marker.
package adm_pkg;

    // Default graph size and domain count.
    localparam int ADM_NODES_DEF   = 64;
    localparam int ADM_DOMAINS_DEF = 4;

    // Fixed field widths of the streams and registers.
    localparam int MODE_W     = 3;
    localparam int NODE_W     = 6;
    localparam int BLOCK_W    = 16;
    localparam int DOMAIN_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int MASK_W     = 64;
    localparam int NODE_CNT_W = 7;
    localparam int DOM_CNT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MARK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SELECT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NODES_USED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DOMAINS_USED = 1'b1;

    // Control bundle from the sequencer to the row store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } adm_row_ctl_t;

endpackage

>>> sv/adm_row_store.sv
// Producer bitmap store: one row per consumer node, with a valid bit per row.
module adm_row_store
    import adm_pkg::*;
#(
    parameter int NODES = ADM_NODES_DEF,
    parameter int NW    = $clog2(NODES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  adm_row_ctl_t     ctl,
    input  logic [NW-1:0]    rd_addr,
    input  logic [NW-1:0]    wr_addr,
    input  logic [NODES-1:0] wr_data,
    output logic [NODES-1:0] rd_row
);

    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] row_vld_reg;
    logic [NODES-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Rows never written since reset or the last clear read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (ctl.clr) begin
                row_vld_reg <= '0;
            end else if (ctl.wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> sv/ancestor_demand_marker_top.sv
// Ancestor demand marker: edge loading, schedule marks and demand traversal.
// One transaction at a time. A select walks rows from the target node, and a row read can
// leave a bubble before its producers are picked. The next transaction is accepted after
// the result is loaded, and a held result stalls the sequencer. Synchronous reset empties
// all state, limits 64/4.
module ancestor_demand_marker_top
    import adm_pkg::*;
#(
    parameter int NODES   = ADM_NODES_DEF,
    parameter int DOMAINS = ADM_DOMAINS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0: mode, producer node, consumer node, value flag,
    // producer block, consumer block, target node, domain.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: status, demanded_mask, then zero fill.
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int NW = $clog2(NODES);
    localparam int DW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam logic [NODE_CNT_W-1:0] NODES_C   = NODE_CNT_W'(NODES);
    localparam logic [4:0]            DOMAINS_C = 5'(DOMAINS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_EDGE = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [NODE_CNT_W-1:0] nodes_used_reg;
    logic [DOM_CNT_W-1:0]  domains_used_reg;

    // Latched input transaction.
    logic [MODE_W-1:0] mode_reg;
    logic [NODE_W-1:0] prod_reg;
    logic [NODE_W-1:0] cons_reg;
    logic              keep_reg;
    logic [NODE_W-1:0] target_reg;
    logic [DOMAIN_W-1:0] dom_reg;

    // Graph and demand state outside the row store.
    logic [NODES-1:0] sched_reg;
    logic [NODES-1:0] dem_reg [DOMAINS];
    logic [DOMAINS-1:0] root_vld_reg;
    logic [NW-1:0]    root_idx_reg [DOMAINS];

    // Traversal state: nodes still to visit and a row read in flight.
    logic [NODES-1:0] pend_reg, pend_next;
    logic             inflight_reg, inflight_next;

    // Result register.
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [MASK_W-1:0]   mask_reg;

    // Row store interface.
    adm_row_ctl_t     row_ctl;
    logic [NW-1:0]    row_rd_addr;
    logic [NODES-1:0] row_wr_data;
    logic [NODES-1:0] row_rd;

    // Decode helpers.
    logic [NODE_CNT_W-1:0] nlim;
    logic [4:0]            dlim;
    logic [NODES-1:0]      vmask;
    logic [NW-1:0]         prod_idx, cons_idx, target_idx;
    logic [DW-1:0]         dom_idx;
    logic                  prod_bad, cons_bad, target_bad, dom_bad;
    logic                  root_busy;
    logic                  out_free;

    // Per-cycle actions decided by the sequencer.
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [NODES-1:0]    emit_mask;
    logic [NODES-1:0]    sched_set;
    logic [NODES-1:0]    dem_set;
    logic                root_wr;
    logic                clr_all;

    // Traversal helpers.
    logic [NODES-1:0] fresh;
    logic [NODES-1:0] pick_onehot;
    logic [NW-1:0]    pick_idx;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign nlim = (nodes_used_reg > NODES_C) ? NODES_C : nodes_used_reg;
    assign dlim = ({2'b00, domains_used_reg} > DOMAINS_C) ? DOMAINS_C
                                                           : {2'b00, domains_used_reg};

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            vmask[i] = (NODE_CNT_W'(i) < nlim);
        end
    end

    assign prod_idx   = NW'(prod_reg);
    assign cons_idx   = NW'(cons_reg);
    assign target_idx = NW'(target_reg);
    assign dom_idx    = DW'(dom_reg);

    assign prod_bad   = ({1'b0, prod_reg} >= nlim);
    assign cons_bad   = ({1'b0, cons_reg} >= nlim);
    assign target_bad = ({1'b0, target_reg} >= nlim);
    assign dom_bad    = ({3'b000, dom_reg} >= dlim);

    // A domain's previous root blocks a new select until it is scheduled.
    assign root_busy = root_vld_reg[dom_idx] && !sched_reg[root_idx_reg[dom_idx]];

    // Lowest pending node is the next row to visit.
    assign pick_onehot = pend_reg & (~pend_reg + NODES'(1));
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < NODES; i++) begin
            pick_idx = pick_idx | (pick_onehot[i] ? NW'(i) : '0);
        end
    end

    // Producers of the visited row that are new, in range and not yet scheduled.
    assign fresh = inflight_reg ? (row_rd & vmask & ~sched_reg & ~dem_reg[dom_idx])
                                : '0;

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        inflight_next = 1'b0;
        emit          = 1'b0;
        emit_status   = STAT_DONE;
        emit_mask     = '0;
        sched_set     = '0;
        dem_set       = '0;
        root_wr       = 1'b0;
        clr_all       = 1'b0;
        row_ctl       = '0;
        row_rd_addr   = cons_idx;
        row_wr_data   = row_rd | (NODES'(1) << prod_idx);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (mode_reg)
                    MODE_LOAD: begin
                        if (prod_bad || cons_bad) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = STAT_RANGE;
                                state_next  = ST_IDLE;
                            end
                        end else if (keep_reg) begin
                            // Fetch the consumer row; the bit is merged into it in ST_EDGE.
                            row_ctl.rd_en = 1'b1;
                            state_next    = ST_EDGE;
                        end else if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_MARK: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (target_bad) begin
                                emit_status = STAT_RANGE;
                            end else begin
                                sched_set = NODES'(1) << target_idx;
                            end
                        end
                    end
                    MODE_SELECT: begin
                        if (dom_bad || target_bad) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = STAT_RANGE;
                                state_next  = ST_IDLE;
                            end
                        end else if (root_busy) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = STAT_IGNORED;
                                emit_mask   = dem_reg[dom_idx];
                                state_next  = ST_IDLE;
                            end
                        end else begin
                            root_wr    = 1'b1;
                            dem_set    = NODES'(1) << target_idx;
                            pend_next  = NODES'(1) << target_idx;
                            state_next = ST_WALK;
                        end
                    end
                    MODE_READ: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (dom_bad) begin
                                emit_status = STAT_RANGE;
                            end else begin
                                emit_mask = dem_reg[dom_idx];
                            end
                        end
                    end
                    MODE_CLEAR: begin
                        if (out_free) begin
                            emit        = 1'b1;
                            clr_all     = 1'b1;
                            row_ctl.clr = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit        = 1'b1;
                            emit_status = STAT_RANGE;
                            state_next  = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_EDGE: begin
                if (out_free) begin
                    row_ctl.wr_en = 1'b1;
                    emit          = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WALK: begin
                // One row read per cycle while nodes are pending; then its producers join.
                dem_set     = fresh;
                row_rd_addr = pick_idx;
                if (pend_reg != '0) begin
                    row_ctl.rd_en = 1'b1;
                    inflight_next = 1'b1;
                    pend_next     = (pend_reg & ~pick_onehot) | fresh;
                end else begin
                    pend_next = fresh;
                    if (!inflight_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_mask  = dem_reg[dom_idx];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            nodes_used_reg   <= NODE_CNT_W'(64);
            domains_used_reg <= DOM_CNT_W'(4);
            sched_reg        <= '0;
            root_vld_reg     <= '0;
            pend_reg         <= '0;
            inflight_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            for (int d = 0; d < DOMAINS; d++) begin
                dem_reg[d]      <= '0;
                root_idx_reg[d] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            inflight_reg <= inflight_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_NODES_USED:   nodes_used_reg   <= cfg_wdata[NODE_CNT_W-1:0];
                    REG_DOMAINS_USED: domains_used_reg <= cfg_wdata[DOM_CNT_W-1:0];
                endcase
            end

            if (clr_all) begin
                sched_reg    <= '0;
                root_vld_reg <= '0;
                for (int d = 0; d < DOMAINS; d++) begin
                    dem_reg[d]      <= '0;
                    root_idx_reg[d] <= '0;
                end
            end else begin
                sched_reg        <= sched_reg | sched_set;
                dem_reg[dom_idx] <= dem_reg[dom_idx] | dem_set;
                if (root_wr) begin
                    root_vld_reg[dom_idx] <= 1'b1;
                    root_idx_reg[dom_idx] <= target_idx;
                end
            end

            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the latched transaction and the result fields.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg   <= s_tdata[2:0];
            prod_reg   <= s_tdata[8:3];
            cons_reg   <= s_tdata[14:9];
            keep_reg   <= s_tdata[15] && (s_tdata[31:16] == s_tdata[47:32]);
            target_reg <= s_tdata[53:48];
            dom_reg    <= s_tdata[55:54];
        end
        if (emit) begin
            status_reg <= emit_status;
            mask_reg   <= MASK_W'(emit_mask);
        end
    end

    adm_row_store #(
        .NODES (NODES),
        .NW    (NW)
    ) u_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (row_ctl),
        .rd_addr (row_rd_addr),
        .wr_addr (cons_idx),
        .wr_data (row_wr_data),
        .rd_row  (row_rd)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - STATUS_W - MASK_W)'(0), mask_reg, status_reg};

endmodule
